[rtl/s1sct_pkg.sv]
// Shared types, constants and lookup tables for the Set-1 scancode translator.
// Used by the front end, the job queue, the result sequencer and the top level.
`timescale 1ns / 1ps

package s1sct_pkg;

    localparam int QueueDepth = 4;

    // Opcodes carried on the request tuser
    localparam logic OpScan  = 1'b0;
    localparam logic OpClear = 1'b1;

    localparam logic [7:0] PrefixByte  = 8'hE0;
    localparam logic [6:0] RegularEnd  = 7'h3B;
    localparam logic [6:0] ExtUp       = 7'h48;
    localparam logic [6:0] ExtDown     = 7'h50;
    localparam logic [6:0] ExtRight    = 7'h4D;
    localparam logic [6:0] ExtLeft     = 7'h4B;
    localparam logic [6:0] ExtCtrl     = 7'h1D;
    localparam logic [6:0] ExtAlt      = 7'h38;
    localparam logic [6:0] UpperMask   = 7'h5F;
    localparam logic [6:0] AsciiEsc    = 7'h1B;
    localparam logic [6:0] AsciiBrack  = 7'h5B;
    localparam logic [6:0] AsciiCapA   = 7'h41;
    localparam logic [6:0] AsciiCapZ   = 7'h5A;
    localparam logic [6:0] CtrlOffset  = 7'h40;

    // Positional key codes
    localparam logic [6:0] KeyLShift = 7'd1;
    localparam logic [6:0] KeyRShift = 7'd2;
    localparam logic [6:0] KeyLCtrl  = 7'd3;
    localparam logic [6:0] KeyRCtrl  = 7'd4;
    localparam logic [6:0] KeyRAlt   = 7'd6;
    localparam logic [6:0] KeyUp     = 7'd8;
    localparam logic [6:0] KeyDown   = 7'd9;
    localparam logic [6:0] KeyLeft   = 7'd10;
    localparam logic [6:0] KeyRight  = 7'd11;

    // Work handed from the front end to the sequencer
    typedef struct packed {
        logic       arrow;     // send ESC [ final before the event
        logic       has_char;  // send chr before the event
        logic [6:0] chr;
        logic [6:0] key;
        logic       pressed;
    } t_job;

    // Tables padded to 64 entries; codes 0x3B and up are filtered before use.
    localparam logic [6:0] PosRom [0:63] = '{
        7'd0,  7'd12, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49,
        7'd50, 7'd51, 7'd52, 7'd43, 7'd54, 7'd55, 7'd13, 7'd14,
        7'd33, 7'd39, 7'd21, 7'd34, 7'd36, 7'd41, 7'd37, 7'd25,
        7'd31, 7'd32, 7'd56, 7'd57, 7'd15, 7'd3,  7'd17, 7'd35,
        7'd20, 7'd22, 7'd23, 7'd24, 7'd26, 7'd27, 7'd28, 7'd59,
        7'd60, 7'd53, 7'd1,  7'd58, 7'd42, 7'd40, 7'd19, 7'd38,
        7'd18, 7'd30, 7'd29, 7'd61, 7'd62, 7'd63, 7'd2,  7'd64,
        7'd5,  7'd16, 7'd7,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
    };

    localparam logic [6:0] ShiftedRom [0:63] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] PlainRom [0:63] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Final letter of the ESC [ x sequence for an arrow key
    function automatic logic [6:0] arrow_final(input logic [6:0] key);
        logic [6:0] fin;
        case (key)
            KeyUp:    fin = 7'h41;
            KeyDown:  fin = 7'h42;
            KeyRight: fin = 7'h43;
            default:  fin = 7'h44;
        endcase
        return fin;
    endfunction

endpackage

[rtl/s1sct_front.sv]
// Front end: takes requests, tracks the shift/ctrl/prefix latches and turns
// each known scancode into a job for the sequencer. Depends on s1sct_pkg.
`timescale 1ns / 1ps

module s1sct_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_opcode,
    input  logic [7:0]       i_scan_byte,
    input  logic             i_queue_full,
    output logic             o_push,
    output s1sct_pkg::t_job  o_job
);

    logic r_shift, r_ctrl, r_prefix;
    logic n_shift, n_ctrl, n_prefix;
    logic       accept;
    logic       pressed;
    logic [6:0] code;
    logic [6:0] key;
    logic [6:0] chr;
    logic [6:0] upper;
    logic       emit;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign pressed = !i_scan_byte[7];
    assign code    = i_scan_byte[6:0];

    always_comb begin
        n_shift = r_shift;
        n_ctrl  = r_ctrl;
        n_prefix = r_prefix;
        key   = '0;
        chr   = '0;
        upper = '0;
        emit  = 1'b0;
        o_job = '0;
        if (i_opcode == s1sct_pkg::OpClear) begin
            n_shift  = 1'b0;
            n_ctrl   = 1'b0;
            n_prefix = 1'b0;
        end else if (i_scan_byte == s1sct_pkg::PrefixByte) begin
            n_prefix = 1'b1;
        end else if (r_prefix) begin
            n_prefix = 1'b0;
            case (code)
                s1sct_pkg::ExtUp:    key = s1sct_pkg::KeyUp;
                s1sct_pkg::ExtDown:  key = s1sct_pkg::KeyDown;
                s1sct_pkg::ExtRight: key = s1sct_pkg::KeyRight;
                s1sct_pkg::ExtLeft:  key = s1sct_pkg::KeyLeft;
                s1sct_pkg::ExtCtrl: begin
                    key    = s1sct_pkg::KeyRCtrl;
                    n_ctrl = pressed;
                end
                s1sct_pkg::ExtAlt:   key = s1sct_pkg::KeyRAlt;
                default:             key = '0;
            endcase
            emit          = (key != '0);
            o_job.arrow   = pressed && (key inside {[s1sct_pkg::KeyUp:s1sct_pkg::KeyRight]});
            o_job.key     = key;
            o_job.pressed = pressed;
        end else if (code < s1sct_pkg::RegularEnd) begin
            key = s1sct_pkg::PosRom[code[5:0]];
            if (key == s1sct_pkg::KeyLShift || key == s1sct_pkg::KeyRShift) begin
                n_shift = pressed;
            end else if (key == s1sct_pkg::KeyLCtrl) begin
                n_ctrl = pressed;
            end
            // latches above already reflect this key before the lookup
            chr = n_shift ? s1sct_pkg::ShiftedRom[code[5:0]] : s1sct_pkg::PlainRom[code[5:0]];
            upper = chr & s1sct_pkg::UpperMask;
            if (n_ctrl && (upper inside {[s1sct_pkg::AsciiCapA:s1sct_pkg::AsciiCapZ]})) begin
                chr = upper - s1sct_pkg::CtrlOffset;
            end
            emit           = (key != '0);
            o_job.has_char = pressed && (chr != '0);
            o_job.chr      = chr;
            o_job.key      = key;
            o_job.pressed  = pressed;
        end
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_prefix <= 1'b0;
        end else if (accept) begin
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_prefix <= n_prefix;
        end
    end

endmodule

[rtl/s1sct_queue.sv]
// Small register queue of jobs between the front end and the sequencer.
// Depends on s1sct_pkg for the job type.
`timescale 1ns / 1ps

module s1sct_queue #(
    parameter int Depth = s1sct_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  s1sct_pkg::t_job  i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output s1sct_pkg::t_job  o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    s1sct_pkg::t_job r_mem [0:Depth-1];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/s1sct_seq.sv]
// Result sequencer: expands each queued job into one to four results and holds
// them in an output register. Depends on s1sct_pkg.
`timescale 1ns / 1ps

module s1sct_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  s1sct_pkg::t_job  i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_is_event,
    output logic [6:0]       o_cooked_char,
    output logic [6:0]       o_key_code,
    output logic             o_key_pressed,
    output logic             o_last
);

    logic [1:0] r_step, last_step;
    logic       r_valid;
    logic       r_is_event, r_pressed;
    logic [6:0] r_char, r_key;
    logic       load, is_ev;
    logic [6:0] chr;

    // event is always the final result of a job
    assign last_step = i_job.arrow ? 2'd3 : (i_job.has_char ? 2'd1 : 2'd0);
    assign is_ev     = (r_step == last_step);
    assign load      = i_job_valid && (!r_valid || i_ready);
    assign o_pop     = load && is_ev;

    always_comb begin
        chr = i_job.chr;
        if (i_job.arrow) begin
            case (r_step)
                2'd0:    chr = s1sct_pkg::AsciiEsc;
                2'd1:    chr = s1sct_pkg::AsciiBrack;
                default: chr = s1sct_pkg::arrow_final(i_job.key);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= is_ev ? 2'd0 : r_step + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_event <= is_ev;
            r_char     <= is_ev ? 7'd0 : chr;
            r_key      <= is_ev ? i_job.key : 7'd0;
            r_pressed  <= is_ev ? i_job.pressed : 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_is_event    = r_is_event;
    assign o_cooked_char = r_char;
    assign o_key_code    = r_key;
    assign o_key_pressed = r_pressed;
    assign o_last        = r_is_event;

endmodule

[rtl/set1_scancode_translator_unit.sv]
// Top level of the Set-1 scancode translator: front end, job queue, sequencer.
// Depends on s1sct_pkg, s1sct_front, s1sct_queue and s1sct_seq.
`timescale 1ns / 1ps

// Translates Set-1 keyboard scancode bytes into cooked ASCII characters and
// positional key events. A request is taken every cycle while the job queue
// has room; the front end updates the shift, ctrl and E0-prefix latches in
// the cycle it takes the request. The sequencer then sends the results of one
// request in order, each held while m_tready is low: one for a plain event, two
// for a key with a character, four for an arrow press (ESC [ x and the event);
// it sustains one result per cycle while m_tready is high. Requests that give
// no result (prefix byte, clear command, unknown codes) push no job.
// tlast marks the final result of a request, tuser set means a key event.
module set1_scancode_translator_unit #(
    parameter int QueueDepth = s1sct_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] cooked_char, [13:7] key_code, [14] key_pressed
    output logic        m_tuser,   // [0] is_event
    output logic        m_tlast
);

    s1sct_pkg::t_job push_job, head_job;
    logic            push, full, pop, head_valid;
    logic [6:0]      cooked_char, key_code;
    logic            key_pressed;

    s1sct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_opcode     (s_tuser),
        .i_scan_byte  (s_tdata),
        .i_queue_full (full),
        .o_push       (push),
        .o_job        (push_job)
    );

    s1sct_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_job)
    );

    s1sct_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (head_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_valid       (m_tvalid),
        .i_ready       (m_tready),
        .o_is_event    (m_tuser),
        .o_cooked_char (cooked_char),
        .o_key_code    (key_code),
        .o_key_pressed (key_pressed),
        .o_last        (m_tlast)
    );

    assign m_tdata = {1'b0, key_pressed, key_code, cooked_char};

endmodule
